@@ rtl/dms_pkg.sv @@
`timescale 1ns / 1ps

package dms_pkg;

  // Frame geometry
  localparam int FRAME_POINTS = 32;
  localparam int ADDR_W       = $clog2(FRAME_POINTS);
  localparam int BIN_W        = ADDR_W - 1;

  // Datapath widths
  localparam int SAMPLE_W = 10;
  localparam int STORE_W  = 16;
  localparam int COEF_W   = 11;
  localparam int PROD_W   = STORE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ABS_W    = ACC_W - 1;
  localparam int QUO_W    = 9;
  localparam int REM_W    = 21;
  localparam int RECIP_W  = 21;
  localparam int MAG_W    = 11;
  localparam int BAR_W    = 4;

  localparam logic [SAMPLE_W-1:0] DC_RESET    = 10'd504;
  localparam logic [RECIP_W-1:0]  RECIP       = 21'd1099511;  // floor(2^40 / 10^6)
  localparam int                  RECIP_SHIFT = 40;
  localparam logic [REM_W-1:0]    DIVISOR     = 21'd1000000;
  localparam logic [BAR_W-1:0]    BAR_MAX     = 4'd14;
  localparam logic [BIN_W-1:0]    LAST_BIN    = 4'd15;
  localparam logic [ADDR_W-1:0]   QUARTER     = 5'd8;

  // First quarter of the sine period, amplitude 1000, rounded to nearest.
  localparam logic signed [COEF_W-1:0] SINE_QTR [9] = '{
    11'sd0, 11'sd195, 11'sd383, 11'sd556, 11'sd707,
    11'sd831, 11'sd924, 11'sd981, 11'sd1000
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_POST
  } state_e;

  typedef struct packed {
    logic              issue;
    logic              clear;
    logic [ADDR_W-1:0] angle;
  } mac_ctrl_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } post_req_t;

  // Full-period sine built from the quarter table by symmetry.
  function automatic logic signed [COEF_W-1:0] sine_val(input logic [ADDR_W-1:0] idx);
    logic [1:0]                quad;
    logic [3:0]                pos;
    logic signed [COEF_W-1:0]  mag;
    quad = idx[ADDR_W-1 -: 2];
    pos  = quad[0] ? (4'd8 - {1'b0, idx[2:0]}) : {1'b0, idx[2:0]};
    mag  = SINE_QTR[pos];
    return quad[1] ? -mag : mag;
  endfunction

endpackage

@@ rtl/dms_frame_ram.sv @@
`timescale 1ns / 1ps

module dms_frame_ram
  import dms_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [STORE_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [STORE_W-1:0] rdata_o
);

  logic [STORE_W-1:0] mem_q [FRAME_POINTS];
  logic [STORE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dms_mac.sv @@
`timescale 1ns / 1ps

module dms_mac
  import dms_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [STORE_W-1:0] sample_i,
  output logic signed [ACC_W-1:0] re_o,
  output logic signed [ACC_W-1:0] im_o,
  output logic                    idle_o
);

  logic                      s1_valid_q, s1_clear_q;
  logic [ADDR_W-1:0]         s1_angle_q;
  logic                      s2_valid_q, s2_clear_q;
  logic signed [COEF_W-1:0]  cos_c, sin_c;
  logic signed [PROD_W-1:0]  prod_re_d, prod_im_d, prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]   re_acc_q, im_acc_q;

  // Stage 1 lines up with the memory read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_clear_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_clear_q <= 1'b0;
    end else begin
      s1_valid_q <= ctrl_i.issue;
      s1_clear_q <= ctrl_i.clear;
      s2_valid_q <= s1_valid_q;
      s2_clear_q <= s1_clear_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_angle_q <= ctrl_i.angle;
  end

  always_comb begin
    sin_c     = sine_val(s1_angle_q);
    cos_c     = sine_val(s1_angle_q + QUARTER);
    prod_re_d = PROD_W'(sample_i) * PROD_W'(cos_c);
    prod_im_d = PROD_W'(sample_i) * PROD_W'(sin_c);
  end

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
  end

  // The imaginary sum accumulates the negated sine products.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      re_acc_q <= (s2_clear_q ? '0 : re_acc_q) + ACC_W'(prod_re_q);
      im_acc_q <= (s2_clear_q ? '0 : im_acc_q) - ACC_W'(prod_im_q);
    end
  end

  assign re_o   = re_acc_q;
  assign im_o   = im_acc_q;
  assign idle_o = !s1_valid_q && !s2_valid_q;

endmodule

@@ rtl/dms_post.sv @@
`timescale 1ns / 1ps

module dms_post
  import dms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  post_req_t        req_i,
  output logic             valid_o,
  output logic [MAG_W-1:0] magnitude_o,
  output logic [BAR_W-1:0] bar_level_o
);

  logic                       va_q, vb_q, vc_q;
  logic [ABS_W-1:0]           a_re_q, a_im_q, b_re_q, b_im_q;
  logic [ABS_W+RECIP_W-1:0]   qp_re, qp_im;
  logic [QUO_W-1:0]           qb_re_q, qb_im_q, qc_re_q, qc_im_q;
  logic [ABS_W-1:0]           back_re, back_im;
  logic [REM_W-1:0]           rem_re_q, rem_im_q;
  logic [QUO_W:0]             qf_re, qf_im, sum_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= req_i.start;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Stage A: absolute values. Truncation toward zero commutes with this.
  always_ff @(posedge clk_i) begin
    a_re_q <= ABS_W'(req_i.re < 0 ? -req_i.re : req_i.re);
    a_im_q <= ABS_W'(req_i.im < 0 ? -req_i.im : req_i.im);
  end

  // Stage B: reciprocal estimate of the quotient, low by at most one.
  always_comb begin
    qp_re = (ABS_W+RECIP_W)'(a_re_q) * (ABS_W+RECIP_W)'(RECIP);
    qp_im = (ABS_W+RECIP_W)'(a_im_q) * (ABS_W+RECIP_W)'(RECIP);
  end

  always_ff @(posedge clk_i) begin
    qb_re_q <= qp_re[RECIP_SHIFT +: QUO_W];
    qb_im_q <= qp_im[RECIP_SHIFT +: QUO_W];
    b_re_q  <= a_re_q;
    b_im_q  <= a_im_q;
  end

  // Stage C: remainder for the one-step correction.
  always_comb begin
    back_re = ABS_W'(qb_re_q) * ABS_W'(DIVISOR);
    back_im = ABS_W'(qb_im_q) * ABS_W'(DIVISOR);
  end

  always_ff @(posedge clk_i) begin
    qc_re_q  <= qb_re_q;
    qc_im_q  <= qb_im_q;
    rem_re_q <= REM_W'(b_re_q - back_re);
    rem_im_q <= REM_W'(b_im_q - back_im);
  end

  // The sum of two corrected quotients over four stays far below the
  // magnitude ceiling, so no saturation stage is needed.
  always_comb begin
    qf_re = {1'b0, qc_re_q} + (QUO_W+1)'(rem_re_q >= DIVISOR);
    qf_im = {1'b0, qc_im_q} + (QUO_W+1)'(rem_im_q >= DIVISOR);
    sum_c = qf_re + qf_im;
    magnitude_o = MAG_W'(sum_c[QUO_W:2]);
    bar_level_o = (magnitude_o > MAG_W'(BAR_MAX)) ? BAR_MAX : magnitude_o[BAR_W-1:0];
  end

  assign valid_o = vc_q;

endmodule

@@ rtl/dft32_magnitude_spectrum_top.sv @@
`timescale 1ns / 1ps
// 32-point DFT magnitude spectrum.
//
// Input channel: one 10-bit converter sample per transfer on adc_sample_i,
// qualified by in_valid_i and held off by in_stall_o. Each sample has the
// dc_offset register subtracted, is scaled by 8 and is written into the next
// entry of a 32-entry frame memory.
// Output channel: every 32nd sample completes a frame and produces sixteen
// transfers, bins 0 to 15 in order, with last_bin_o marking bin 15.
// The configuration register is written by cfg_we_i / cfg_wdata_i.
//
// Throughput: samples are accepted back to back until a frame is complete.
// The frame then runs through a single complex multiply-accumulate unit
// fed by the frame memory, one sample per cycle. Once the multiply
// pipeline has drained, each bin's sums pass division stages A, B and C
// before the next bin starts. The input is stalled while the spectrum is
// computed.
// If the receiver stalls, the finished bin waits in the output register and
// the next bin is held before its division step until that register drains.
// Reset clears fill position and output valid flag; offset resets to 504.

module dft32_magnitude_spectrum_top
  import dms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] adc_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BIN_W-1:0]    bin_index_o,
  output logic [MAG_W-1:0]    magnitude_o,
  output logic [BAR_W-1:0]    bar_level_o,
  output logic                last_bin_o
);

  state_e                  state_q, state_d;
  logic [ADDR_W-1:0]       fill_q, fill_d;
  logic [ADDR_W-1:0]       k_q, k_d;
  logic [ADDR_W-1:0]       angle_q, angle_d;
  logic [BIN_W-1:0]        bin_q, bin_d;
  logic [SAMPLE_W-1:0]     dc_q;

  logic                    in_xfer;
  logic signed [SAMPLE_W:0] diff_c;
  logic [STORE_W-1:0]      wdata_c;
  logic [STORE_W-1:0]      rdata;

  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] mac_re, mac_im;
  logic                    mac_idle;
  post_req_t               post_req;
  logic                    post_valid;
  logic [MAG_W-1:0]        post_mag;
  logic [BAR_W-1:0]        post_bar;

  logic                    out_load;
  logic                    out_valid_q, out_valid_d;
  logic [BIN_W-1:0]        out_bin_q;
  logic [MAG_W-1:0]        out_mag_q;
  logic [BAR_W-1:0]        out_bar_q;
  logic                    out_last_q;

  // Offset register; new values apply to later samples only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= DC_RESET;
    end else if (cfg_we_i) begin
      dc_q <= cfg_wdata_i;
    end
  end

  // Samples are taken only between frames.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    diff_c  = $signed({1'b0, adc_sample_i}) - $signed({1'b0, dc_q});
    wdata_c = {{(STORE_W-SAMPLE_W-4){diff_c[SAMPLE_W]}}, diff_c, 3'b000};
  end

  dms_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (fill_q),
    .wdata_i (wdata_c),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  dms_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i ($signed(rdata)),
    .re_o     (mac_re),
    .im_o     (mac_im),
    .idle_o   (mac_idle)
  );

  dms_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (post_req),
    .valid_o     (post_valid),
    .magnitude_o (post_mag),
    .bar_level_o (post_bar)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      k_q     <= '0;
      angle_q <= '0;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      k_q     <= k_d;
      angle_q <= angle_d;
      bin_q   <= bin_d;
    end
  end

  // Sequencer: fill the frame, then per bin stream all 32 samples through
  // the MAC unit, wait for the pipeline to empty and the output register to
  // be free, and hand the sums to the division pipeline.
  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    k_d            = k_q;
    angle_d        = angle_q;
    bin_d          = bin_q;
    mac_ctrl       = '0;
    post_req.start = 1'b0;
    post_req.re    = mac_re;
    post_req.im    = mac_im;
    out_load       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          fill_d = fill_q + 1'b1;
          if (fill_q == ADDR_W'(FRAME_POINTS - 1)) begin
            state_d = ST_MAC;
            bin_d   = '0;
            k_d     = '0;
            angle_d = '0;
          end
        end
      end
      ST_MAC: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.clear = (k_q == '0);
        mac_ctrl.angle = angle_q;
        k_d            = k_q + 1'b1;
        angle_d        = angle_q + {1'b0, bin_q};
        if (k_q == ADDR_W'(FRAME_POINTS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_idle && !out_valid_q) begin
          post_req.start = 1'b1;
          state_d        = ST_POST;
        end
      end
      ST_POST: begin
        if (post_valid) begin
          out_load = 1'b1;
          if (bin_q == LAST_BIN) begin
            state_d = ST_IDLE;
          end else begin
            bin_d   = bin_q + 1'b1;
            k_d     = '0;
            angle_d = '0;
            state_d = ST_MAC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register. It is always empty when a result is loaded.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bin_q  <= bin_q;
      out_mag_q  <= post_mag;
      out_bar_q  <= post_bar;
      out_last_q <= (bin_q == LAST_BIN);
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = out_bin_q;
  assign magnitude_o = out_mag_q;
  assign bar_level_o = out_bar_q;
  assign last_bin_o  = out_last_q;

endmodule

@@ rtl/dms_checker.sv @@
`timescale 1ns / 1ps

module dms_checker
  import dms_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [BIN_W-1:0]    bin_index_o,
  input logic [MAG_W-1:0]    magnitude_o,
  input logic [BAR_W-1:0]    bar_level_o,
  input logic                last_bin_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_index_o) &&
      $stable(magnitude_o) && $stable(bar_level_o) && $stable(last_bin_o))
    else $error("stalled result changed");

  // Bar level is the magnitude clipped at the bar ceiling, and the last flag
  // marks the top bin.
  a_bar_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((magnitude_o > MAG_W'(BAR_MAX) && bar_level_o == BAR_MAX) ||
       (magnitude_o <= MAG_W'(BAR_MAX) && bar_level_o == magnitude_o[BAR_W-1:0])) &&
      (last_bin_o == (bin_index_o == LAST_BIN)))
    else $error("bar level or last flag inconsistent");

  // While a frame's spectrum is still being produced, no sample is taken.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_bin_o |-> in_stall_o)
    else $error("sample input open in the middle of a spectrum");

  // Bins are produced one per accumulation pass, never back to back.
  a_bin_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result followed another without a gap");

endmodule

bind dft32_magnitude_spectrum_top dms_checker u_dms_checker (.*);
